// ===== design/hlpi_pkg.sv =====
// hlpi_pkg: shared types and constants for the hough line pair intersection block
// no dependencies; compiled first

package hlpi_pkg;

  // store depth default
  localparam int MAX_LINES_DEF = 64;

  // configuration register indexes
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RHO_STEP     = 3'd2;
  localparam logic [2:0] CFG_THETA_STEP   = 3'd3;
  localparam logic [2:0] CFG_MAX_SIDE     = 3'd4;

  // configuration reset values
  localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [15:0] RHO_STEP_RST     = 16'd256;
  localparam logic [15:0] THETA_STEP_RST   = 16'd64;
  localparam logic [12:0] MAX_SIDE_RST     = 13'd512;

  // fixed point constants
  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
  localparam logic signed [15:0] EPS_Q15  = 16'sd33;
  localparam logic [35:0]        RHO_MAX  = 36'd2097151;

  // cordic arctangent steps in binary angle units
  localparam logic [13:0] ATAN_TAB [16] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
  };

  // channel payloads
  typedef struct packed {
    logic               new_set;
    logic signed [11:0] rho_index;
    logic [9:0]         theta_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [5:0]  partner_index;
    logic        found;
    logic        dropped;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_item_t;

endpackage

// ===== design/hlpi_stream_if.sv =====
// hlpi_stream_if: valid/ready channel carrying one payload of type T
// no dependencies; payload types come from hlpi_pkg

interface hlpi_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/hough_line_pair_intersections.sv =====
// hough_line_pair_intersections: intersects each new hough line with all stored lines
// depends on hlpi_pkg and hlpi_stream_if
//
// Usage:
//   in_ch   takes one line (new_set, rho_index, theta_index) per transfer. The block
//           takes one line at a time; in_ch.ready is high only while it waits for a line.
//   out_ch  gives one result per stored partner line, in slot order, last set on the
//           final one; the first line of a set gives one empty result.
//   cfg_ch  writes image_width, image_height, rho_step, theta_step, max_side by index;
//           always ready, write only while no line is in work.
// Work per line:
//   setup: rho scaling, with the larger_side/max_side rescale divide when rho needs it,
//   then the cordic for the line's angle; per stored partner: cordic on the angle difference,
//   products, then the two 1-bit-per-cycle dividers unless the pair is near parallel.
//   The 16-step cordic and the dividers do the iterative work.
// Stored lines sit in one memory (rho, angle, sine, cosine), read one per partner.
// Reset empties the store and loads the default configuration; memory needs no clear.
// A stalled receiver holds the result register and the block waits on it.

module hough_line_pair_intersections #(
  parameter int MAX_LINES = hlpi_pkg::MAX_LINES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  hlpi_stream_if.sink   in_ch,
  hlpi_stream_if.source out_ch,
  hlpi_stream_if.sink   cfg_ch
);
  import hlpi_pkg::*;

  localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam logic [5:0] DIV_LAST = 6'd39;
  localparam logic [5:0] COR_LAST = 6'd15;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_SCALE  = 15'h0002,
    S_RDIV   = 15'h0004,
    S_RHO    = 15'h0008,
    S_TRIG_I = 15'h0010,
    S_CHECK  = 15'h0020,
    S_PRD    = 15'h0040,
    S_PANG   = 15'h0080,
    S_PCOR   = 15'h0100,
    S_PMUL   = 15'h0200,
    S_PSUB   = 15'h0400,
    S_PDIV   = 15'h0800,
    S_PFIN   = 15'h1000,
    S_POUT   = 15'h2000,
    S_DONE   = 15'h4000
  } state_t;

  typedef struct packed {
    logic signed [21:0] rho;
    logic [15:0]        ang;
    logic signed [15:0] sin;
    logic signed [15:0] cos;
  } line_t;

  typedef struct packed {
    logic [39:0] num;
    logic [16:0] rem;
  } div_t;

  // one restoring divide step: shift in the next numerator bit, subtract if it fits
  function automatic div_t div_step(input div_t s, input logic [15:0] den);
    div_t        r;
    logic [16:0] sh;
    sh = {s.rem[15:0], s.num[39]};
    if (sh >= {1'b0, den}) begin
      r.rem = sh - {1'b0, den};
      r.num = {s.num[38:0], 1'b1};
    end else begin
      r.rem = sh;
      r.num = {s.num[38:0], 1'b0};
    end
    return r;
  endfunction

  // round half up from Q2.30 to Q1.15 with saturation
  function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [18:0] q;
    t = $signed({v[32], v}) + 34'sd16384;
    q = 19'(t >>> 15);
    if (q > 19'sd32767) begin
      to_q15 = 16'sh7fff;
    end else if (q < -19'sd32768) begin
      to_q15 = 16'sh8000;
    end else begin
      to_q15 = q[15:0];
    end
  endfunction

  state_t state_r, state_nxt;

  // configuration registers
  logic [12:0] img_w_r, img_h_r, max_side_r;
  logic [15:0] rho_step_r, theta_step_r;

  // line in work
  logic [CW-1:0]      count_r;
  logic               neg_r;
  logic [26:0]        mag_r;
  logic [15:0]        ang_i_r;
  logic signed [21:0] rho_i_r;
  logic signed [15:0] si_r, ci_r;

  // partner in work
  logic [AW-1:0]      k_r;
  line_t              rd_r;
  logic signed [21:0] rj_r;
  logic signed [15:0] sj_r, cj_r, fm_r;
  logic signed [37:0] p1_r, p2_r, p3_r, p4_r;

  // iterative units
  logic [5:0]         it_r;
  logic signed [32:0] cx_r, cy_r;
  logic signed [17:0] cz_r;
  logic               flip_r;
  div_t               dx_r, dy_r;
  logic [15:0]        den_r;
  logic               x_neg_r, y_neg_r;

  // result staging and output register
  logic [15:0] res_x_r, res_y_r;
  logic [5:0]  res_k_r;
  logic        res_found_r, res_last_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  line_t mem [MAX_LINES];

  // geometry helpers
  logic [12:0] larger, ms;
  logic        scale_en, full_c, last_c, out_load, mem_we;
  assign larger   = (img_w_r > img_h_r) ? img_w_r : img_h_r;
  assign ms       = (max_side_r == 13'd0) ? 13'd1 : max_side_r;
  assign scale_en = larger > ms;
  assign full_c   = count_r == CW'(MAX_LINES);
  assign last_c   = (CW'(k_r) + CW'(1)) == count_r;
  assign out_load = (state_r == S_POUT) && (!out_valid_r || out_ch.ready);
  assign mem_we   = out_load && res_last_r && !full_c;

  // input decode
  logic [11:0] rho_abs;
  logic [25:0] ang_prod;
  assign rho_abs  = in_ch.data.rho_index[11] ? 12'(-in_ch.data.rho_index)
                                             : 12'(in_ch.data.rho_index);
  assign ang_prod = 26'(in_ch.data.theta_index) * 26'(theta_step_r);

  // rho truncation to Q.4, saturation and sign
  logic [35:0]        rho_m36;
  logic [20:0]        rho_mag;
  logic signed [21:0] rho_c;
  assign rho_m36 = dx_r.num[39:4];
  assign rho_mag = (rho_m36 > RHO_MAX) ? 21'h1fffff : rho_m36[20:0];
  assign rho_c   = neg_r ? -$signed({1'b0, rho_mag}) : $signed({1'b0, rho_mag});

  // cordic setup: fold the angle into [-quarter, quarter]
  logic [15:0]        cor_ang;
  logic signed [17:0] z0, z_init;
  logic               flip_init;
  always_comb begin
    cor_ang   = (state_r == S_RHO) ? ang_i_r : (rd_r.ang - ang_i_r);
    z0        = $signed({{2{cor_ang[15]}}, cor_ang});
    z_init    = z0;
    flip_init = 1'b0;
    if (z0 > 18'sd16384) begin
      z_init    = z0 - 18'sd32768;
      flip_init = 1'b1;
    end else if (z0 < -18'sd16384) begin
      z_init    = z0 + 18'sd32768;
      flip_init = 1'b1;
    end
  end

  // cordic rotation step
  logic [3:0]         ci;
  logic signed [32:0] xs, ys, cx_nxt, cy_nxt;
  logic signed [17:0] az, cz_nxt;
  always_comb begin
    ci = it_r[3:0];
    xs = cx_r >>> ci;
    ys = cy_r >>> ci;
    az = $signed({4'b0, ATAN_TAB[ci]});
    if (!cz_r[17]) begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - az;
    end else begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + az;
    end
  end

  // cordic outputs
  logic signed [15:0] sin_q, cos_q;
  logic               fm_ok;
  assign sin_q = to_q15(flip_r ? -cy_r : cy_r);
  assign cos_q = to_q15(flip_r ? -cx_r : cx_r);
  assign fm_ok = (sin_q >= EPS_Q15) || (sin_q <= -EPS_Q15);

  // numerators and divider setup
  logic signed [38:0] xn, yn;
  logic [38:0]        xn_mag, yn_mag;
  assign xn     = $signed({p1_r[37], p1_r}) - $signed({p2_r[37], p2_r});
  assign yn     = $signed({p3_r[37], p3_r}) - $signed({p4_r[37], p4_r});
  assign xn_mag = xn[38] ? 39'(-xn) : 39'(xn);
  assign yn_mag = yn[38] ? 39'(-yn) : 39'(yn);

  div_t dx_step, dy_step;
  assign dx_step = div_step(dx_r, den_r);
  assign dy_step = div_step(dy_r, den_r);

  // floor quotient, centre offset and bounds
  logic [41:0] qx, qy, xq, yq;
  logic        in_img;
  always_comb begin
    qx = x_neg_r ? (42'(0) - {2'b0, dx_r.num} - 42'(|dx_r.rem)) : {2'b0, dx_r.num};
    qy = y_neg_r ? (42'(0) - {2'b0, dy_r.num} - 42'(|dy_r.rem)) : {2'b0, dy_r.num};
    xq = qx + 42'({img_w_r[12:1], 4'b0});
    yq = qy + 42'({img_h_r[12:1], 4'b0});
    in_img = !xq[41] && (xq < 42'({img_w_r, 4'b0})) &&
             !yq[41] && (yq < 42'({img_h_r, 4'b0}));
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_ch.valid) state_nxt = S_SCALE;
      S_SCALE:  state_nxt = scale_en ? S_RDIV : S_RHO;
      S_RDIV:   if (it_r == DIV_LAST) state_nxt = S_RHO;
      S_RHO:    state_nxt = S_TRIG_I;
      S_TRIG_I: if (it_r == COR_LAST) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (count_r == CW'(0)) ? S_POUT : S_PRD;
      S_PRD:    state_nxt = S_PANG;
      S_PANG:   state_nxt = S_PCOR;
      S_PCOR:   if (it_r == COR_LAST) state_nxt = S_PMUL;
      S_PMUL:   state_nxt = fm_ok ? S_PSUB : S_POUT;
      S_PSUB:   state_nxt = S_PDIV;
      S_PDIV:   if (it_r == DIV_LAST) state_nxt = S_PFIN;
      S_PFIN:   state_nxt = S_POUT;
      S_POUT:   if (out_load) state_nxt = res_last_r ? S_DONE : S_PRD;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control, configuration and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      img_w_r      <= IMAGE_WIDTH_RST;
      img_h_r      <= IMAGE_HEIGHT_RST;
      rho_step_r   <= RHO_STEP_RST;
      theta_step_r <= THETA_STEP_RST;
      max_side_r   <= MAX_SIDE_RST;
    end else begin
      state_r <= state_nxt;

      // configuration write transfer
      if (cfg_ch.valid) begin
        case (cfg_ch.data.index)
          CFG_IMAGE_WIDTH:  img_w_r      <= cfg_ch.data.data[12:0];
          CFG_IMAGE_HEIGHT: img_h_r      <= cfg_ch.data.data[12:0];
          CFG_RHO_STEP:     rho_step_r   <= cfg_ch.data.data;
          CFG_THETA_STEP:   theta_step_r <= cfg_ch.data.data;
          CFG_MAX_SIDE:     max_side_r   <= cfg_ch.data.data[12:0];
          default: ;
        endcase
      end

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{x_pos: res_x_r, y_pos: res_y_r, partner_index: res_k_r,
                         found: res_found_r, dropped: full_c, last: res_last_r};
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.data.new_set) count_r <= '0;
            neg_r   <= in_ch.data.rho_index[11];
            mag_r   <= 27'(28'(rho_abs) * 28'(rho_step_r));
            ang_i_r <= ang_prod[15:0];
          end
        end
        S_SCALE: begin
          dx_r.num <= scale_en ? 40'(mag_r) * 40'(larger) : 40'(mag_r);
          dx_r.rem <= '0;
          den_r    <= 16'(ms);
          it_r     <= '0;
        end
        S_RDIV: begin
          dx_r <= dx_step;
          it_r <= it_r + 6'd1;
        end
        S_RHO, S_PANG: begin
          if (state_r == S_RHO) begin
            rho_i_r <= rho_c;
          end else begin
            rj_r <= rd_r.rho;
            sj_r <= rd_r.sin;
            cj_r <= rd_r.cos;
          end
          cx_r   <= CORDIC_K;
          cy_r   <= '0;
          cz_r   <= z_init;
          flip_r <= flip_init;
          it_r   <= '0;
        end
        S_TRIG_I, S_PCOR: begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          it_r <= it_r + 6'd1;
        end
        S_CHECK: begin
          si_r        <= sin_q;
          ci_r        <= cos_q;
          k_r         <= '0;
          res_x_r     <= '0;
          res_y_r     <= '0;
          res_k_r     <= '0;
          res_found_r <= 1'b0;
          res_last_r  <= 1'b1;
        end
        S_PMUL: begin
          fm_r        <= sin_q;
          p1_r        <= rho_i_r * sj_r;
          p2_r        <= rj_r * si_r;
          p3_r        <= rj_r * ci_r;
          p4_r        <= rho_i_r * cj_r;
          res_x_r     <= '0;
          res_y_r     <= '0;
          res_k_r     <= 6'(k_r);
          res_found_r <= 1'b0;
          res_last_r  <= last_c;
        end
        S_PSUB: begin
          dx_r.num <= {1'b0, xn_mag};
          dy_r.num <= {1'b0, yn_mag};
          dx_r.rem <= '0;
          dy_r.rem <= '0;
          den_r    <= fm_r[15] ? 16'(-fm_r) : 16'(fm_r);
          x_neg_r  <= xn[38] ^ fm_r[15];
          y_neg_r  <= yn[38] ^ fm_r[15];
          it_r     <= '0;
        end
        S_PDIV: begin
          dx_r <= dx_step;
          dy_r <= dy_step;
          it_r <= it_r + 6'd1;
        end
        S_PFIN: begin
          res_found_r <= in_img;
          res_x_r     <= in_img ? xq[15:0] : 16'd0;
          res_y_r     <= in_img ? yq[15:0] : 16'd0;
        end
        S_POUT: begin
          if (out_load) begin
            if (mem_we) count_r <= count_r + CW'(1);
            if (!res_last_r) k_r <= k_r + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // line store: written once per kept line, read once per partner
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[AW-1:0]] <= '{rho: rho_i_r, ang: ang_i_r, sin: si_r, cos: ci_r};
    if (state_r == S_PRD) rd_r <= mem[k_r];
  end

  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== test/tb_hough_line_pair_intersections.sv =====
// tb_hough_line_pair_intersections: self-checking testbench for the hough line pair block
// depends on hlpi_pkg, hlpi_stream_if and hough_line_pair_intersections
// an in-bench cordic/cramer predictor fills a result queue that a checker drains
`timescale 1ns / 1ps

module tb_hough_line_pair_intersections;
  import hlpi_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst_n;

  hlpi_stream_if #(.T(in_item_t))  in_ch ();
  hlpi_stream_if #(.T(out_item_t)) out_ch ();
  hlpi_stream_if #(.T(cfg_item_t)) cfg_ch ();

  hough_line_pair_intersections dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow configuration and line store
  int unsigned img_w, img_h, rho_step_q8, theta_step_bam, max_side_px;
  int          stored_rho [STORE_DEPTH];
  logic [15:0] stored_angle [STORE_DEPTH];
  int unsigned stored_count;

  out_item_t pending_results [$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        quiet_cycles;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // q2.30 to q1.15, round half up, saturate
  function automatic int round_q15(input longint v);
    longint q;
    q = (v + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  // 16-step cordic sine and cosine of a binary angle
  function automatic void cordic_sin_cos(input logic [15:0] ang, output int s, output int c);
    longint z, x, y, nx, ny;
    bit     flip;
    z = ang;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768;
      flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = round_q15(y);
    c = round_q15(x);
  endfunction

  function automatic longint div_floor(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  // work out the intersections one accepted line causes
  function automatic void predict_intersections(input in_item_t line);
    longint      mag, xn, yn, xq, yq, rj;
    int unsigned larger, ms;
    int          rho_i, si, ci, sj, cj, fm, dummy;
    logic [15:0] ang_i;
    bit          neg, full, ok;
    out_item_t   r;
    if (line.new_set) stored_count = 0;
    larger = (img_w > img_h) ? img_w : img_h;
    ms = (max_side_px != 0) ? max_side_px : 1;
    neg = line.rho_index < 0;
    mag = neg ? -longint'(line.rho_index) : longint'(line.rho_index);
    mag = mag * rho_step_q8;
    if (larger > ms) mag = mag * larger / ms;
    mag = mag >> 4;
    if (mag > 2097151) mag = 2097151;
    rho_i = neg ? -int'(mag) : int'(mag);
    ang_i = 16'((32'(line.theta_index) * theta_step_bam) & 32'hFFFF);
    cordic_sin_cos(ang_i, si, ci);
    full = stored_count >= STORE_DEPTH;
    if (stored_count == 0) begin
      r = '0;
      r.dropped = full;
      r.last = 1'b1;
      pending_results = {pending_results, r};
    end else begin
      for (int k = 0; k < stored_count; k++) begin
        rj = stored_rho[k];
        ok = 1'b0;
        r = '0;
        cordic_sin_cos(stored_angle[k] - ang_i, fm, dummy);
        cordic_sin_cos(stored_angle[k], sj, cj);
        if (fm >= 33 || fm <= -33) begin
          xn = longint'(rho_i) * sj - rj * si;
          yn = rj * ci - longint'(rho_i) * cj;
          xq = div_floor(xn, fm) + longint'(img_w / 2) * 16;
          yq = div_floor(yn, fm) + longint'(img_h / 2) * 16;
          if (xq >= 0 && xq < longint'(img_w) * 16 && yq >= 0 && yq < longint'(img_h) * 16) begin
            ok = 1'b1;
            r.x_pos = 16'(xq);
            r.y_pos = 16'(yq);
          end
        end
        r.partner_index = 6'(k);
        r.found = ok;
        r.dropped = full;
        r.last = (k == stored_count - 1);
        pending_results = {pending_results, r};
      end
    end
    if (!full) begin
      stored_rho[stored_count] = rho_i;
      stored_angle[stored_count] = ang_i;
      stored_count++;
    end
  endfunction

  // receiver with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation waiting");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.data.x_pos !== exp_r.x_pos) begin
          $error("x_pos expected %0d actual %0d", exp_r.x_pos, out_ch.data.x_pos);
          error_count++;
        end
        if (out_ch.data.y_pos !== exp_r.y_pos) begin
          $error("y_pos expected %0d actual %0d", exp_r.y_pos, out_ch.data.y_pos);
          error_count++;
        end
        if (out_ch.data.partner_index !== exp_r.partner_index) begin
          $error("partner_index expected %0d actual %0d", exp_r.partner_index,
                 out_ch.data.partner_index);
          error_count++;
        end
        if (out_ch.data.found !== exp_r.found) begin
          $error("found expected %0d actual %0d", exp_r.found, out_ch.data.found);
          error_count++;
        end
        if (out_ch.data.dropped !== exp_r.dropped) begin
          $error("dropped expected %0d actual %0d", exp_r.dropped, out_ch.data.dropped);
          error_count++;
        end
        if (out_ch.data.last !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, out_ch.data.last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[hough_line_pair_intersections] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one line transfer; valid stays high so back-to-back lines need no gap
  task automatic send_line(input bit new_set, input int rho, input int theta);
    in_item_t it;
    int       gap;
    it.new_set = new_set;
    it.rho_index = 12'(rho);
    it.theta_index = 10'(theta);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_intersections(it);
  endtask

  // drop valid and wait for every result, then for the tail latency
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    cfg_item_t c;
    c.index = idx;
    c.data = 16'(value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = value & 16'h1FFF;
      CFG_IMAGE_HEIGHT: img_h = value & 16'h1FFF;
      CFG_RHO_STEP:     rho_step_q8 = value & 16'hFFFF;
      CFG_THETA_STEP:   theta_step_bam = value & 16'hFFFF;
      CFG_MAX_SIDE:     max_side_px = value & 16'h1FFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned rs,
                            input int unsigned ts, input int unsigned ms);
    drain_results();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_RHO_STEP, rs);
    write_reg(CFG_THETA_STEP, ts);
    write_reg(CFG_MAX_SIDE, ms);
  endtask

  // mostly modest rho so that intersections land inside the image
  function automatic int pick_rho();
    if ($urandom_range(99) < 70) return $urandom_range(600) - 300;
    return $urandom_range(4095) - 2048;
  endfunction

  // one set of lines; new_set on the first
  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_line(i == 0, pick_rho(), $urandom_range(1023));
  endtask

  // defaults: empty store, near parallel pair, field extremes
  task automatic test_default_lines();
    send_line(1'b1, 100, 0);
    send_line(1'b0, 50, 256);
    send_line(1'b0, 80, 256);
    send_line(1'b0, -120, 512);
    send_line(1'b0, 2047, 1023);
    send_line(1'b0, -2048, 768);
    send_line(1'b0, 0, 1);
    send_line(1'b1, -1, 1023);
    send_line(1'b0, 10, 0);
  endtask

  // angle wrap and zero theta step
  task automatic test_angle_wrap();
    set_config(640, 480, 256, 65535, 512);
    send_line(1'b1, 30, 1023);
    send_line(1'b0, -30, 1);
    send_line(1'b0, 60, 512);
    set_config(640, 480, 256, 0, 512);
    send_line(1'b1, 20, 5);
    send_line(1'b0, 40, 900);
  endtask

  // store full: 64 kept, later lines flagged dropped
  task automatic test_store_full();
    set_config(640, 480, 256, 64, 512);
    for (int i = 0; i < STORE_DEPTH + 2; i++)
      send_line(i == 0, $urandom_range(200) - 100, $urandom_range(1023));
  endtask

  // extreme register settings, rescale path included
  task automatic test_config_extremes();
    set_config(1, 1, 1, 1, 1);
    send_random_set(4);
    set_config(4096, 4096, 65535, 65535, 4096);
    send_random_set(4);
    set_config(4096, 300, 256, 64, 1);
    send_random_set(4);
    set_config(0, 0, 256, 64, 0);
    send_random_set(3);
    set_config(8191, 8191, 16, 100, 8191);
    send_random_set(4);
    set_config($urandom_range(8191), $urandom_range(8191), $urandom_range(65535),
               $urandom_range(65535), $urandom_range(8191));
    send_random_set(4);
    set_config(640, 480, 256, 64, 512);
  endtask

  // random sets under three idling profiles
  task automatic test_random_sets();
    int sent, n;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 37 : 0;
      if (phase == 2)
        set_config(800, 600, 128 + $urandom_range(384), 64, 400);
      sent = 0;
      while (sent < 88) begin
        n = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(24, 7);
        send_random_set(n);
        sent += n;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    error_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 62;
    img_w = IMAGE_WIDTH_RST;
    img_h = IMAGE_HEIGHT_RST;
    rho_step_q8 = RHO_STEP_RST;
    theta_step_bam = THETA_STEP_RST;
    max_side_px = MAX_SIDE_RST;
    stored_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_lines();
    test_angle_wrap();
    test_config_extremes();
    test_store_full();
    test_random_sets();
    drain_results();

    if (error_count == 0) begin
      $display("[hough_line_pair_intersections] OK");
    end else begin
      $display("[hough_line_pair_intersections] ERROR");
    end
    $finish;
  end

endmodule
